### sv/retransmit_slot_table_unit_assert.svh
// Assertion macros for the retransmit slot table.
`ifndef RETRANSMIT_SLOT_TABLE_UNIT_ASSERT_SVH
`define RETRANSMIT_SLOT_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// A condition that holds at every clock edge outside reset.
`define RSTU_ASSERT_HOLD(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("retransmit slot table: invariant violated");
// A consequence that must hold in the cycle after its trigger.
`define RSTU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("retransmit slot table: sequence violated");
`else
`define RSTU_ASSERT_HOLD(lbl, clk, rst, prop)
`define RSTU_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### sv/rstab_pkg.sv
// Shared types and constants of the retransmit slot table.
package rstab_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam logic [7:0] RESEND_RESET = 8'd3;

   localparam logic [1:0] CMD_RESERVE = 2'd0;
   localparam logic [1:0] CMD_PUSH    = 2'd1;
   localparam logic [1:0] CMD_NEXT    = 2'd2;
   localparam logic [1:0] CMD_CLEAR   = 2'd3;

   // One stored entry: handle, send time and remaining retry budget.
   typedef struct packed {
      logic [31:0] tag;
      logic [31:0] stamp;
      logic [7:0]  retries;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

### sv/rstab_ram.sv
// Simple dual-port entry memory with one write port and a registered read port.
module rstab_ram #(
   parameter int DEPTH  = rstab_pkg::SLOTS_DEFAULT,
   parameter int WIDTH  = rstab_pkg::ENTRY_W,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/retransmit_slot_table_unit.sv
// Top level of the retransmit slot table: command sequencer, slot flags and entry memory.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_tvalid/tready     tuser = cmd, tdata = entry and clear fields
//   rsp      out        rsp_tvalid/tready     tdata = grant, pick result, held count
//   csr      in         csr_wr_en             csr_wr_data = resend interval
//
// Reserve and clear finish in the accept cycle; their result reaches rsp through the done
// state and the output register. Push walks the slot flags one per cycle. Next reads the
// entry memory one slot per cycle through its registered read port and evaluates each
// slot as its entry comes out, so a pick visits every slot.
// Reset clears the slot flags, the held count and the handshakes at once; there is no sweep.
// One command is worked on at a time; a new one is taken while the last result still waits.
`include "retransmit_slot_table_unit_assert.svh"

module retransmit_slot_table_unit #(
   parameter int SLOTS = rstab_pkg::SLOTS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   // Command channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // [1:0] cmd
   input  logic [111:0] req_tdata,   // [31:0] entry_tag, [63:32] entry_time,
                                     // [71:64] entry_retries, [103:72] now_seconds,
                                     // [111:104] slot_index
   // Result channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // [0] reserve_granted, [1] found, [9:2] found_slot,
                                     // [41:10] found_tag, [49:42] found_retries_left,
                                     // [57:50] held_count, [63:58] zero
   // Resend interval register.
   input  logic         csr_wr_en,
   input  logic [7:0]   csr_wr_data
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [7:0] SLOTS_B = 8'(SLOTS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // Input fields.
   logic [1:0]  in_cmd;
   logic [31:0] in_tag;
   logic [31:0] in_time;
   logic [7:0]  in_retries;
   logic [31:0] in_now;
   logic [7:0]  in_index;

   assign in_cmd     = req_tuser;
   assign in_tag     = req_tdata[31:0];
   assign in_time    = req_tdata[63:32];
   assign in_retries = req_tdata[71:64];
   assign in_now     = req_tdata[103:72];
   assign in_index   = req_tdata[111:104];

   logic [1:0]       state_ff, state_in;
   logic [1:0]       cmd_ff;
   logic [31:0]      tag_ff, time_ff, now_ff;
   logic [7:0]       retries_ff;
   logic [7:0]       interval_ff;
   logic [SLOTS-1:0] used_ff, used_in;
   logic [7:0]       reserved_ff, reserved_in;
   logic [IDX_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic             issue_ff, issue_in;
   logic             pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0] pipe_idx_ff, pipe_idx_in;
   logic             res_granted_ff, res_granted_in;
   logic             res_found_ff, res_found_in;
   logic [7:0]       res_slot_ff, res_slot_in;
   logic [31:0]      res_tag_ff, res_tag_in;
   logic [7:0]       res_ret_ff, res_ret_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [63:0]      rsp_data_ff, rsp_data_in;

   // Entry memory ports.
   logic                     mem_wr_en;
   logic [IDX_W-1:0]         mem_wr_addr;
   rstab_pkg::entry_type     mem_wr_entry;
   logic                     mem_rd_en;
   logic [rstab_pkg::ENTRY_W-1:0] mem_rd_data;
   rstab_pkg::entry_type     rd_entry;

   // Pick evaluation of the slot whose entry has just come out of memory.
   logic        cur_used;
   logic [31:0] age;
   logic        due;
   logic [7:0]  new_ret;
   logic        accept;
   logic        rsp_load;
   logic        pick_scan;

   assign accept    = req_tvalid && req_tready;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign rd_entry  = rstab_pkg::entry_type'(mem_rd_data);
   assign pick_scan = (state_ff == ST_SCAN) && (cmd_ff == rstab_pkg::CMD_NEXT);

   assign cur_used = used_ff[pipe_idx_ff];
   assign age      = now_ff - rd_entry.stamp;
   assign due      = cur_used && !res_found_ff && (age >= {24'd0, interval_ff});
   // A picked entry with no retries left stays at zero and expires below.
   assign new_ret  = (due && (rd_entry.retries != 8'd0)) ? rd_entry.retries - 8'd1
                                                         : rd_entry.retries;

   always_comb begin
      state_in       = state_ff;
      used_in        = used_ff;
      reserved_in    = reserved_ff;
      scan_cnt_in    = scan_cnt_ff;
      issue_in       = issue_ff;
      pipe_vld_in    = 1'b0;
      pipe_idx_in    = pipe_idx_ff;
      res_granted_in = res_granted_ff;
      res_found_in   = res_found_ff;
      res_slot_in    = res_slot_ff;
      res_tag_in     = res_tag_ff;
      res_ret_in     = res_ret_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = scan_cnt_ff;
      mem_wr_entry   = '{tag: tag_ff, stamp: time_ff, retries: retries_ff};
      mem_rd_en      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_granted_in = 1'b0;
               res_found_in   = 1'b0;
               res_slot_in    = 8'd0;
               res_tag_in     = 32'd0;
               res_ret_in     = 8'd0;
               scan_cnt_in    = '0;
               issue_in       = 1'b1;
               unique case (in_cmd)
                  rstab_pkg::CMD_RESERVE: begin
                     if (reserved_ff < SLOTS_B) begin
                        reserved_in    = reserved_ff + 8'd1;
                        res_granted_in = 1'b1;
                     end
                     state_in = ST_DONE;
                  end
                  rstab_pkg::CMD_CLEAR: begin
                     if ((in_index < SLOTS_B) && used_ff[in_index[IDX_W-1:0]]) begin
                        used_in[in_index[IDX_W-1:0]] = 1'b0;
                        if (reserved_ff != 8'd0) begin
                           reserved_in = reserved_ff - 8'd1;
                        end
                     end
                     state_in = ST_DONE;
                  end
                  rstab_pkg::CMD_PUSH,
                  rstab_pkg::CMD_NEXT: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (cmd_ff == rstab_pkg::CMD_PUSH) begin
               // First free slot takes the entry; a full table drops it.
               if (!used_ff[scan_cnt_ff]) begin
                  mem_wr_en            = 1'b1;
                  used_in[scan_cnt_ff] = 1'b1;
                  state_in             = ST_DONE;
               end else if (scan_cnt_ff == LAST_IDX) begin
                  state_in = ST_DONE;
               end else begin
                  scan_cnt_in = scan_cnt_ff + 1'b1;
               end
            end else begin
               // Reads run one slot ahead of the evaluation; each slot is read once
               // and written back at most once, so the two never meet on one entry.
               if (issue_ff) begin
                  mem_rd_en   = 1'b1;
                  pipe_vld_in = 1'b1;
                  pipe_idx_in = scan_cnt_ff;
                  if (scan_cnt_ff == LAST_IDX) begin
                     issue_in = 1'b0;
                  end else begin
                     scan_cnt_in = scan_cnt_ff + 1'b1;
                  end
               end
               if (pipe_vld_ff) begin
                  mem_wr_addr  = pipe_idx_ff;
                  mem_wr_entry = '{tag: rd_entry.tag, stamp: now_ff, retries: new_ret};
                  if (due) begin
                     mem_wr_en    = 1'b1;
                     res_found_in = 1'b1;
                     res_slot_in  = 8'(pipe_idx_ff);
                     res_tag_in   = rd_entry.tag;
                     res_ret_in   = new_ret;
                  end
                  if (cur_used && (new_ret == 8'd0)) begin
                     used_in[pipe_idx_ff] = 1'b0;
                     if (reserved_ff != 8'd0) begin
                        reserved_in = reserved_ff - 8'd1;
                     end
                  end
                  if (pipe_idx_ff == LAST_IDX) begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: loaded from the finished command, emptied when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, reserved_ff, res_ret_ff, res_tag_ff, res_slot_ff,
                         res_found_ff, res_granted_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         reserved_ff  <= 8'd0;
         interval_ff  <= rstab_pkg::RESEND_RESET;
         pipe_vld_ff  <= 1'b0;
         issue_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         reserved_ff  <= reserved_in;
         pipe_vld_ff  <= pipe_vld_in;
         issue_ff     <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            interval_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= in_cmd;
         tag_ff     <= in_tag;
         time_ff    <= in_time;
         retries_ff <= in_retries;
         now_ff     <= in_now;
      end
      scan_cnt_ff    <= scan_cnt_in;
      pipe_idx_ff    <= pipe_idx_in;
      res_granted_ff <= res_granted_in;
      res_found_ff   <= res_found_in;
      res_slot_ff    <= res_slot_in;
      res_tag_ff     <= res_tag_in;
      res_ret_ff     <= res_ret_in;
      rsp_data_ff    <= rsp_data_in;
   end

   rstab_ram #(
      .DEPTH  (SLOTS),
      .WIDTH  (rstab_pkg::ENTRY_W),
      .ADDR_W (IDX_W)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_entry),
      .rd_en   (mem_rd_en),
      .rd_addr (scan_cnt_ff),
      .rd_data (mem_rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The held count never passes the number of slots.
   `RSTU_ASSERT_HOLD(a_held_bound, clock, reset, reserved_ff <= SLOTS_B)
   // Memory read results are only evaluated during a pick scan.
   `RSTU_ASSERT_HOLD(a_pipe_in_scan, clock, reset, !pipe_vld_ff || pick_scan)
   // Only one command is in flight at a time.
   `RSTU_ASSERT_NEXT(a_one_in_flight, clock, reset, accept, !req_tready)
   // A result never claims both a grant and a pick.
   `RSTU_ASSERT_HOLD(a_rsp_kind, clock, reset, !(rsp_valid_ff && rsp_data_ff[0] && rsp_data_ff[1]))

endmodule
